// ----- src/eegpd_pkg.sv -----
// ----------------------------------------------------------------------------
// EEG packet deframer package
// Shared constants, types and the sample unpack helper.
// ----------------------------------------------------------------------------
package eegpd_pkg;

   localparam int NUM_CHAN      = 6;
   localparam int F0_DATA_LEN   = 12;   // data bytes in a two-sync-byte packet
   localparam int F1_FRAME_LEN  = 11;   // bytes in a sync-bit packet

   localparam logic [7:0] SYNC_FIRST  = 8'hA5;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;

   localparam logic FMT_TWO_SYNC = 1'b0;
   localparam logic FMT_SYNC_BIT = 1'b1;

   typedef logic [15:0] word_type;
   typedef logic [7:0]  byte_type;
   typedef logic [3:0]  index_type;

   // 10-bit sample: low seven bits from one byte, top three from the shared byte
   function automatic word_type f1_sample(input byte_type lo_b, input logic [2:0] hi_bits);
      f1_sample = {6'b000000, hi_bits, lo_b[6:0]};
   endfunction

endpackage

// ----- src/eeg_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// EEG packet deframer
// Deframes six-channel EEG packets from a byte stream, two-sync-byte or
// sync-bit format selected by a configuration register.
// ----------------------------------------------------------------------------
// Result timing: a result is valid in the cycle after the transaction of a packet's last byte.
// Throughput: one byte per cycle; the single result register stalls input only
// while a result waits and rsp_ready is low.
// Reset (synchronous): parser back to hunting, byte index, count, switches and
// format cleared, no result pending. Frame and channel storage is not cleared.
module eeg_packet_deframer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  eegpd_pkg::byte_type  req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output eegpd_pkg::word_type  rsp_chan0,
   output eegpd_pkg::word_type  rsp_chan1,
   output eegpd_pkg::word_type  rsp_chan2,
   output eegpd_pkg::word_type  rsp_chan3,
   output eegpd_pkg::word_type  rsp_chan4,
   output eegpd_pkg::word_type  rsp_chan5,
   output eegpd_pkg::byte_type  rsp_packet_number,
   output eegpd_pkg::byte_type  rsp_button_state,
   output eegpd_pkg::byte_type  rsp_aux_byte
);
   import eegpd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC    = 3'd1,   // second sync byte, or frame collection in sync-bit format
      PH_VERSION = 3'd2,
      PH_COUNT   = 3'd3,
      PH_DATA    = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   index_type  idx_ff, idx_in;
   byte_type   count_ff, count_in;
   byte_type   switches_ff, switches_in;
   logic       fmt_ff;

   byte_type   frame_ff [F1_FRAME_LEN-1];
   word_type   cw_ff [NUM_CHAN];

   logic       rsp_valid_ff;
   word_type   rsp_chan_ff [NUM_CHAN];
   byte_type   rsp_num_ff, rsp_btn_ff, rsp_aux_ff;

   logic       accept;
   logic       emit;
   logic       frame_we, cw_we;
   index_type  fidx;
   logic [2:0] cw_sel;
   word_type   res_chan [NUM_CHAN];
   byte_type   res_num, res_btn, res_aux;
   byte_type   f [F1_FRAME_LEN];
   byte_type   num1, aux1;
   logic       sync_ok;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // frame index wraps to zero if it was left out of range
   assign fidx   = (idx_ff >= index_type'(F1_FRAME_LEN)) ? '0 : idx_ff;
   assign cw_sel = idx_ff[3:1];

   always_comb begin
      for (int k = 0; k < F1_FRAME_LEN - 1; k++) begin
         f[k] = frame_ff[k];
      end
      f[F1_FRAME_LEN-1] = req_rx_byte;
      num1 = {2'b00, f[0][6:1]};
      aux1 = {f[0][0], f[1][6:0]};
      sync_ok = f[F1_FRAME_LEN-1][7];
      for (int k = 0; k < F1_FRAME_LEN - 1; k++) begin
         if (f[k][7]) sync_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      switches_in = switches_ff;
      frame_we    = 1'b0;
      cw_we       = 1'b0;
      emit        = 1'b0;
      res_num     = count_ff;
      res_aux     = '0;
      for (int k = 0; k < NUM_CHAN; k++) begin
         res_chan[k] = cw_ff[k];
      end
      if (fmt_ff == FMT_TWO_SYNC) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == SYNC_FIRST) phase_in = PH_SYNC;
            end
            PH_SYNC: begin
               phase_in = (req_rx_byte == SYNC_SECOND) ? PH_VERSION : PH_HUNT;
            end
            PH_VERSION: begin
               phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               count_in = req_rx_byte;
               idx_in   = '0;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               if (idx_ff < index_type'(F0_DATA_LEN)) begin
                  cw_we  = 1'b1;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  switches_in = req_rx_byte;
                  phase_in    = PH_HUNT;
                  idx_in      = '0;
                  emit        = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end else begin
         for (int g = 0; g < 3; g++) begin
            res_chan[2*g]   = f1_sample(f[2+3*g], f[4+3*g][6:4]);
            res_chan[2*g+1] = f1_sample(f[3+3*g], f[4+3*g][2:0]);
         end
         res_num = num1;
         res_aux = aux1;
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte[7]) begin
                  idx_in   = '0;
                  phase_in = PH_SYNC;
               end
            end
            PH_SYNC: begin
               if (fidx == index_type'(F1_FRAME_LEN - 1)) begin
                  // last byte of the frame
                  if (num1[2:0] == 3'd4) switches_in = aux1;
                  idx_in   = '0;
                  phase_in = sync_ok ? PH_SYNC : PH_HUNT;
                  emit     = sync_ok;
               end else begin
                  frame_we = 1'b1;
                  idx_in   = fidx + 4'd1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
      res_btn = switches_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         idx_ff       <= '0;
         count_ff     <= '0;
         switches_ff  <= '0;
         fmt_ff       <= FMT_TWO_SYNC;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) fmt_ff <= csr_wr_data;
         if (accept) begin
            phase_ff    <= phase_in;
            idx_ff      <= idx_in;
            count_ff    <= count_in;
            switches_ff <= switches_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_we) frame_ff[fidx] <= req_rx_byte;
      if (accept && cw_we) begin
         if (!idx_ff[0]) begin
            cw_ff[cw_sel] <= {req_rx_byte, 8'h00};
         end else begin
            cw_ff[cw_sel][7:0] <= req_rx_byte;
         end
      end
      if (accept && emit) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            rsp_chan_ff[k] <= res_chan[k];
         end
         rsp_num_ff <= res_num;
         rsp_btn_ff <= res_btn;
         rsp_aux_ff <= res_aux;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chan0         = rsp_chan_ff[0];
   assign rsp_chan1         = rsp_chan_ff[1];
   assign rsp_chan2         = rsp_chan_ff[2];
   assign rsp_chan3         = rsp_chan_ff[3];
   assign rsp_chan4         = rsp_chan_ff[4];
   assign rsp_chan5         = rsp_chan_ff[5];
   assign rsp_packet_number = rsp_num_ff;
   assign rsp_button_state  = rsp_btn_ff;
   assign rsp_aux_byte      = rsp_aux_ff;

   // parser restarts hunting after reset
   a_reset_hunt: assert property (@(posedge clock)
      $past(reset) |-> (phase_ff == PH_HUNT && idx_ff == '0))
      else $error("parser not hunting after reset");

   // byte index never runs past the data field
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= index_type'(F0_DATA_LEN))
      else $error("byte index out of range");

   // a new result only follows an accepted transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result without an input transaction");

endmodule

// ----- tb/sv/eeg_packet_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// EEG packet deframer testbench
// Feeds byte streams in both packet formats through the valid/ready input,
// predicts each deframed packet in a local parser model and checks every
// result field by field. Covers false sync, back-to-back sync-bit packets,
// sync errors, switches updates, mid-packet format changes, output stalls
// and random traffic with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module eeg_packet_deframer_tb;
   import eegpd_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int LONG_HOLD      = 150;
   localparam int RANDOM_PHASES  = 8;
   localparam int RANDOM_BYTES   = 1750;
   localparam int NO_SYNC_ERROR  = -1;

   // parser phases; phase 1 is the second sync byte in format 0 and
   // frame collection in format 1
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_ARMED   = 3'd1,
      PH_VERSION = 3'd2,
      PH_COUNT   = 3'd3,
      PH_DATA    = 3'd4
   } parse_state_type;

   typedef struct packed {
      word_type [NUM_CHAN-1:0] chan;
      byte_type                number;
      byte_type                buttons;
      byte_type                aux;
   } deframed_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_wr_en;
   logic     csr_wr_data;
   logic     req_valid;
   logic     req_ready;
   byte_type req_rx_byte;
   logic     rsp_valid;
   logic     rsp_ready;
   word_type rsp_chan0, rsp_chan1, rsp_chan2, rsp_chan3, rsp_chan4, rsp_chan5;
   byte_type rsp_packet_number;
   byte_type rsp_button_state;
   byte_type rsp_aux_byte;

   word_type [NUM_CHAN-1:0] rsp_chan;
   assign rsp_chan = {rsp_chan5, rsp_chan4, rsp_chan3, rsp_chan2, rsp_chan1, rsp_chan0};

   // parser model state
   logic            fmt_now     = FMT_TWO_SYNC;
   parse_state_type parse_state = PH_HUNT;
   int              frame_pos   = 0;
   byte_type        frame_buf [F1_FRAME_LEN];
   word_type        chan_words [NUM_CHAN];
   byte_type        count_byte  = '0;
   byte_type        switch_byte = '0;

   deframed_type pending_frames [$];
   deframed_type head_frame;

   int error_count  = 0;
   int bytes_sent   = 0;
   bit req_gaps     = 1'b0;
   bit rsp_gaps     = 1'b0;
   bit hold_request = 1'b0;

   eeg_packet_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chan0         (rsp_chan0),
      .rsp_chan1         (rsp_chan1),
      .rsp_chan2         (rsp_chan2),
      .rsp_chan3         (rsp_chan3),
      .rsp_chan4         (rsp_chan4),
      .rsp_chan5         (rsp_chan5),
      .rsp_packet_number (rsp_packet_number),
      .rsp_button_state  (rsp_button_state),
      .rsp_aux_byte      (rsp_aux_byte)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   function automatic byte_type rand_byte();
      return byte_type'($urandom);
   endfunction

   // advance the parser model by one accepted byte
   function automatic void deframe_byte(input byte_type b);
      deframed_type     frame;
      logic [5:0]       counter;
      byte_type         aux;
      bit               sync_ok;
      int               j;
      word_type [NUM_CHAN-1:0] samples;
      frame = '0;
      if (fmt_now == FMT_TWO_SYNC) begin
         case (parse_state)
            PH_HUNT: if (b == SYNC_FIRST) parse_state = PH_ARMED;
            PH_ARMED: parse_state = (b == SYNC_SECOND) ? PH_VERSION : PH_HUNT;
            PH_VERSION: parse_state = PH_COUNT;
            PH_COUNT: begin
               count_byte  = b;
               frame_pos   = 0;
               parse_state = PH_DATA;
            end
            PH_DATA: begin
               if (frame_pos < F0_DATA_LEN) begin
                  if (frame_pos % 2 == 0)
                     chan_words[frame_pos / 2] = {b, 8'h00};
                  else
                     chan_words[frame_pos / 2][7:0] = b;
                  frame_pos++;
               end else begin
                  switch_byte = b;
                  parse_state = PH_HUNT;
                  frame_pos   = 0;
                  for (int k = 0; k < NUM_CHAN; k++)
                     frame.chan[k] = chan_words[k];
                  frame.number  = count_byte;
                  frame.buttons = switch_byte;
                  frame.aux     = '0;
                  pending_frames.push_back(frame);
               end
            end
            default: parse_state = PH_HUNT;
         endcase
      end else if (parse_state == PH_HUNT) begin
         if (b[7]) begin
            frame_pos   = 0;
            parse_state = PH_ARMED;
         end
      end else if (parse_state != PH_ARMED) begin
         parse_state = PH_HUNT;
      end else begin
         if (frame_pos >= F1_FRAME_LEN) frame_pos = 0;
         frame_buf[frame_pos] = b;
         frame_pos++;
         if (frame_pos == F1_FRAME_LEN) begin
            counter = frame_buf[0][6:1];
            aux     = {frame_buf[0][0], frame_buf[1][6:0]};
            // switches load even when the sync check fails
            if (counter[2:0] == 3'd4) switch_byte = aux;
            sync_ok = frame_buf[10][7];
            for (int k = 0; k < F1_FRAME_LEN - 1; k++)
               if (frame_buf[k][7]) sync_ok = 1'b0;
            for (int g = 0; g < 3; g++) begin
               j = 2 + 3 * g;
               samples[2*g]   = {6'b000000, frame_buf[j+2][6:4], frame_buf[j][6:0]};
               samples[2*g+1] = {6'b000000, frame_buf[j+2][2:0], frame_buf[j+1][6:0]};
            end
            frame_pos = 0;
            if (!sync_ok) begin
               parse_state = PH_HUNT;
            end else begin
               for (int k = 0; k < NUM_CHAN; k++)
                  chan_words[k] = samples[k];
               parse_state   = PH_ARMED;
               frame.chan    = samples;
               frame.number  = {2'b00, counter};
               frame.buttons = switch_byte;
               frame.aux     = aux;
               pending_frames.push_back(frame);
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic send_byte(input byte_type value);
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
      deframe_byte(value);
   endtask

   // register writes only with the input quiet and no packet outstanding
   task automatic set_format(input logic fmt);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fmt_now = fmt;
   endtask

   task automatic send_two_sync_packet(input byte_type count, input byte_type button,
                                       input bit random_data, input byte_type fill);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(rand_byte());
      send_byte(count);
      repeat (F0_DATA_LEN) send_byte(random_data ? rand_byte() : fill);
      send_byte(button);
   endtask

   task automatic send_sync_bit_packet(input logic [5:0] counter, input byte_type aux,
                                       input bit random_data, input byte_type fill,
                                       input int bad_pos);
      byte_type frame [F1_FRAME_LEN];
      while (parse_state != PH_ARMED) send_byte(rand_byte() | 8'h80);
      frame[0] = {1'b0, counter, aux[7]};
      frame[1] = {1'b0, aux[6:0]};
      for (int k = 2; k < F1_FRAME_LEN; k++)
         frame[k] = (random_data ? rand_byte() : fill) & 8'h7F;
      frame[F1_FRAME_LEN-1][7] = 1'b1;
      if (bad_pos == F1_FRAME_LEN - 1)
         frame[bad_pos][7] = 1'b0;
      else if (bad_pos >= 0)
         frame[bad_pos][7] = 1'b1;
      for (int k = 0; k < F1_FRAME_LEN; k++)
         send_byte(frame[k]);
   endtask

   task automatic test_two_sync_frames();
      set_format(FMT_TWO_SYNC);
      // a repeated A5 drops back to hunting, so this 5A is just noise
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_two_sync_packet(8'h00, 8'hFF, 1'b0, 8'hFF);
      send_two_sync_packet(8'hFF, 8'h00, 1'b0, 8'h00);
   endtask

   task automatic test_sync_bit_frames();
      set_format(FMT_SYNC_BIT);
      send_sync_bit_packet(6'd4, 8'hFF, 1'b0, 8'h7F, NO_SYNC_ERROR);
      // follows directly, no hunt byte
      send_sync_bit_packet(6'd63, 8'h00, 1'b0, 8'h00, NO_SYNC_ERROR);
      // sync error with counter low bits 4: switches still take the aux byte
      send_sync_bit_packet(6'd12, 8'h5A, 1'b1, 8'h00, 3);
      send_sync_bit_packet(6'd20, 8'hC3, 1'b1, 8'h00, F1_FRAME_LEN - 1);
      send_sync_bit_packet(6'd0, 8'h81, 1'b1, 8'h00, NO_SYNC_ERROR);
   endtask

   task automatic test_format_switch();
      set_format(FMT_TWO_SYNC);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(rand_byte());
      send_byte(rand_byte());
      repeat (3) send_byte(rand_byte());
      // data phase has no meaning in the sync-bit format
      set_format(FMT_SYNC_BIT);
      send_sync_bit_packet(6'($urandom), rand_byte(), 1'b1, 8'h00, NO_SYNC_ERROR);
      repeat (4) send_byte(rand_byte() & 8'h7F);
      // collecting phase now reads as waiting for the second sync byte
      set_format(FMT_TWO_SYNC);
      send_byte(SYNC_SECOND);
      repeat (F0_DATA_LEN + 3) send_byte(rand_byte());
   endtask

   task automatic test_backpressure();
      set_format(FMT_SYNC_BIT);
      req_gaps     = 1'b0;
      rsp_gaps     = 1'b0;
      hold_request = 1'b1;
      repeat (6)
         send_sync_bit_packet(6'($urandom), rand_byte(), 1'b1, 8'h00, NO_SYNC_ERROR);
   endtask

   task automatic test_random_traffic();
      int   stop_at;
      int   pick;
      logic fmt;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         fmt = (ph < 2) ? logic'(ph % 2) : logic'($urandom_range(0, 1));
         set_format(fmt);
         // the last phase runs with no idling
         req_gaps = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_gaps = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         stop_at  = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
         while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               repeat ($urandom_range(1, 6)) send_byte(rand_byte());
            end else if (fmt_now == FMT_TWO_SYNC) begin
               if (pick == 1) begin
                  send_byte(SYNC_FIRST);
                  repeat ($urandom_range(1, 8)) send_byte(rand_byte());
               end else begin
                  send_two_sync_packet(rand_byte(), rand_byte(), 1'b1, 8'h00);
               end
            end else if (pick == 1) begin
               send_sync_bit_packet(6'($urandom), rand_byte(), 1'b1, 8'h00,
                                    $urandom_range(0, F1_FRAME_LEN - 1));
            end else begin
               send_sync_bit_packet(6'($urandom), rand_byte(), 1'b1, 8'h00,
                                    NO_SYNC_ERROR);
            end
         end
      end
   endtask

   // result side: random stalls, plus one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("unexpected transaction, packet_number",
                            16'(rsp_packet_number), 16'(0));
         end else begin
            head_frame = pending_frames.pop_front();
            for (int k = 0; k < NUM_CHAN; k++)
               if (rsp_chan[k] !== head_frame.chan[k])
                  report_mismatch($sformatf("chan%0d", k), rsp_chan[k], head_frame.chan[k]);
            if (rsp_packet_number !== head_frame.number)
               report_mismatch("packet_number", 16'(rsp_packet_number),
                               16'(head_frame.number));
            if (rsp_button_state !== head_frame.buttons)
               report_mismatch("button_state", 16'(rsp_button_state),
                               16'(head_frame.buttons));
            if (rsp_aux_byte !== head_frame.aux)
               report_mismatch("aux_byte", 16'(rsp_aux_byte), 16'(head_frame.aux));
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_two_sync_frames();
      test_sync_bit_frames();
      test_format_switch();
      test_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
